// ----- design/positional_list_insert_delete_unit_defines.svh -----
// Assertion macros for the positional list unit.
`ifndef POSITIONAL_LIST_INSERT_DELETE_UNIT_DEFINES_SVH
`define POSITIONAL_LIST_INSERT_DELETE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define PLIL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("plil check failed");

// Next-cycle implication, disabled in reset.
`define PLIL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("plil check failed");

`endif

// ----- design/plil_pkg.sv -----
`default_nettype none
package plil_pkg;

    localparam int LIST_CAP = 16;
    localparam int IDX_W    = $clog2(LIST_CAP);
    localparam int CNT_W    = 5;
    localparam int FUNC_W   = 3;
    localparam int DATA_W   = 32;

    typedef enum logic [FUNC_W-1:0] {
        FN_READ     = 3'd0,
        FN_INS_HEAD = 3'd1,
        FN_INS_TAIL = 3'd2,
        FN_INS_POS  = 3'd3,
        FN_DELETE   = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic [CNT_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        t_status                  status;
        logic [CNT_W-1:0]         length;
    } t_rsp;

endpackage
`default_nettype wire

// ----- design/plil_req_if.sv -----
`default_nettype none
interface plil_req_if import plil_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic [CNT_W-1:0]         position;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, func, position, value, input ready);
    modport sink   (input valid, func, position, value, output ready);
endinterface
`default_nettype wire

// ----- design/plil_rsp_if.sv -----
`default_nettype none
interface plil_rsp_if import plil_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] read_value;
    t_status                  status;
    logic [CNT_W-1:0]         length;

    modport source (output valid, read_value, status, length, input ready);
    modport sink   (input valid, read_value, status, length, output ready);
endinterface
`default_nettype wire

// ----- design/plil_shift_array.sv -----
`default_nettype none
module plil_shift_array import plil_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire t_req i_req,
    output t_rsp      o_rsp
);

    logic signed [DATA_W-1:0] r_entries [LIST_CAP];
    logic signed [DATA_W-1:0] n_entries [LIST_CAP];
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic [CNT_W-1:0]         ins_pos;
    logic                     do_ins;
    logic                     do_del;

    always_comb begin
        o_rsp.read_value = '1;
        o_rsp.status     = ST_DONE;
        n_count          = r_count;
        ins_pos          = i_req.position;
        do_ins           = 1'b0;
        do_del           = 1'b0;
        unique case (t_func'(i_req.func))
            FN_READ: begin
                if (i_req.position < r_count) begin
                    o_rsp.read_value = r_entries[i_req.position[IDX_W-1:0]];
                end else begin
                    o_rsp.status = ST_RANGE;
                end
            end
            FN_INS_HEAD, FN_INS_TAIL, FN_INS_POS: begin
                priority if (t_func'(i_req.func) == FN_INS_HEAD) begin
                    ins_pos = '0;
                end else if (t_func'(i_req.func) == FN_INS_TAIL) begin
                    ins_pos = r_count;
                end else begin
                    ins_pos = i_req.position;
                end
                priority if (ins_pos > r_count) begin
                    o_rsp.status = ST_RANGE;
                end else if (r_count == CNT_W'(LIST_CAP)) begin
                    o_rsp.status = ST_FULL;
                end else begin
                    do_ins  = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            FN_DELETE: begin
                if (i_req.position < r_count) begin
                    do_del  = 1'b1;
                    n_count = r_count - CNT_W'(1);
                end else begin
                    o_rsp.status = ST_RANGE;
                end
            end
            default: begin
            end
        endcase
        o_rsp.length = n_count;
    end

    for (genvar g = 0; g < LIST_CAP; g++) begin : g_lane
        localparam int PREV = (g == 0) ? 0 : g - 1;
        localparam int NEXT = (g == LIST_CAP - 1) ? g : g + 1;

        always_comb begin
            n_entries[g] = r_entries[g];
            if (do_ins) begin
                if (CNT_W'(g) == ins_pos) begin
                    n_entries[g] = i_req.value;
                end else if (CNT_W'(g) > ins_pos) begin
                    n_entries[g] = r_entries[PREV];
                end
            end else if (do_del) begin
                if (CNT_W'(g) >= i_req.position) begin
                    n_entries[g] = r_entries[NEXT];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_entries[g] <= n_entries[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_en) begin
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

// ----- design/positional_list_insert_delete_unit.sv -----
// Channel  Dir  Payload                         Handshake
// i_req    in   func, position, value           valid/ready
// o_rsp    out  read_value, status, length      valid/ready
//
// One request per cycle while o_rsp is not stalled; each request passes the
// request register, then the response register. The shift array moves all
// entries at once, so each request is done combinationally between them.
// Synchronous active-low reset empties the list; entry contents are not reset.
// Back-pressure on o_rsp stalls the request register, then i_req.ready drops.
`default_nettype none
module positional_list_insert_delete_unit import plil_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    plil_req_if.sink  i_req,
    plil_rsp_if.source o_rsp
);

    t_req r_req;
    logic r_req_vld;
    t_rsp r_rsp;
    logic r_rsp_vld;
    t_rsp w_rsp;
    logic w_adv;
    logic w_req_rdy;

    assign w_adv     = !r_rsp_vld || o_rsp.ready;
    assign w_req_rdy = !r_req_vld || w_adv;

    assign i_req.ready      = w_req_rdy;
    assign o_rsp.valid      = r_rsp_vld;
    assign o_rsp.read_value = r_rsp.read_value;
    assign o_rsp.status     = r_rsp.status;
    assign o_rsp.length     = r_rsp.length;

    plil_shift_array u_array (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (r_req_vld && w_adv),
        .i_req   (r_req),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
            r_rsp_vld <= 1'b0;
        end else begin
            if (w_req_rdy) begin
                r_req_vld <= i_req.valid;
            end
            if (w_adv) begin
                r_rsp_vld <= r_req_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && w_req_rdy) begin
            r_req.func     <= i_req.func;
            r_req.position <= i_req.position;
            r_req.value    <= i_req.value;
        end
        if (r_req_vld && w_adv) begin
            r_rsp <= w_rsp;
        end
    end

endmodule
`default_nettype wire

// ----- design/plil_checker.sv -----
`default_nettype none
`include "positional_list_insert_delete_unit_defines.svh"
module plil_checker import plil_pkg::*; (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     i_req_valid,
    input wire logic                     i_req_ready,
    input wire logic                     i_rsp_valid,
    input wire logic                     i_rsp_ready,
    input wire logic signed [DATA_W-1:0] i_rsp_read_value,
    input wire t_status                  i_rsp_status,
    input wire logic [CNT_W-1:0]         i_rsp_length
);

    // stalled response beat stays
    `PLIL_ASSERT_NXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid)

    // never beyond capacity
    `PLIL_ASSERT_IMP(a_len_cap, i_clk, i_rst_n, i_rsp_valid, i_rsp_length <= CNT_W'(LIST_CAP))

    // full only when the list really is full
    `PLIL_ASSERT_IMP(a_full_len, i_clk, i_rst_n, i_rsp_valid && i_rsp_status == ST_FULL, i_rsp_length == CNT_W'(LIST_CAP))

    // a read that hits returns done
    `PLIL_ASSERT_IMP(a_rd_done, i_clk, i_rst_n, i_rsp_valid && i_rsp_read_value != '1, i_rsp_status == ST_DONE)

    // no request beat can be refused while the response side is free
    `PLIL_ASSERT_IMP(a_req_rdy, i_clk, i_rst_n, !i_rsp_valid, i_req_ready || !i_req_valid || i_req_ready == 1'b0 && $past(i_req_valid))

endmodule

bind positional_list_insert_delete_unit plil_checker u_plil_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_rsp_read_value (o_rsp.read_value),
    .i_rsp_status     (o_rsp.status),
    .i_rsp_length     (o_rsp.length)
);
`default_nettype wire

// ----- bench/tb_positional_list_insert_delete_unit.sv -----
module tb_positional_list_insert_delete_unit;
    import plil_pkg::*;

    localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;
    localparam int RANDOM_ITEMS   = 850;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    // Mirror of the list plus the queue of responses still owed by the block.
    class list_scoreboard;
        logic signed [DATA_W-1:0] slots [LIST_CAP];
        int   fill;
        int   errors;
        t_rsp owed [$];

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        function void note_request(t_req r);
            t_rsp e;
            int   p;
            int   i;
            e.read_value = -1;
            e.status     = ST_DONE;
            p            = r.position;
            case (r.func)
                FN_READ: begin
                    if (p < fill)
                        e.read_value = slots[p];
                    else
                        e.status = ST_RANGE;
                end
                FN_INS_HEAD, FN_INS_TAIL, FN_INS_POS: begin
                    if (r.func == FN_INS_HEAD)
                        p = 0;
                    else if (r.func == FN_INS_TAIL)
                        p = fill;
                    // range check takes priority over full
                    if (p > fill) begin
                        e.status = ST_RANGE;
                    end else if (fill >= LIST_CAP) begin
                        e.status = ST_FULL;
                    end else begin
                        for (i = fill; i > p; i--)
                            slots[i] = slots[i-1];
                        slots[p] = r.value;
                        fill++;
                    end
                end
                FN_DELETE: begin
                    if (p < fill) begin
                        for (i = p; i + 1 < fill; i++)
                            slots[i] = slots[i+1];
                        fill--;
                    end else begin
                        e.status = ST_RANGE;
                    end
                end
                default: ;
            endcase
            e.length = CNT_W'(fill);
            owed.push_back(e);
        endfunction

        function void check_response(t_rsp got);
            t_rsp e;
            if (owed.size() == 0) begin
                $display("%0t: unexpected response rv=%0d st=%0d len=%0d",
                         $time, got.read_value, got.status, got.length);
                errors++;
                return;
            end
            e = owed.pop_front();
            if (got.read_value !== e.read_value) begin
                $display("%0t: read_value expected %0d got %0d",
                         $time, e.read_value, got.read_value);
                errors++;
            end
            if (got.status !== e.status) begin
                $display("%0t: status expected %0d got %0d", $time, e.status, got.status);
                errors++;
            end
            if (got.length !== e.length) begin
                $display("%0t: length expected %0d got %0d", $time, e.length, got.length);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    plil_req_if req_ch ();
    plil_rsp_if rsp_ch ();

    positional_list_insert_delete_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    list_scoreboard sb = new();

    int unsigned send_idle_pct [4] = '{0, 48, 0, 35};
    int unsigned recv_stall_pct [4] = '{0, 0, 48, 35};
    int          idle_mode;
    int          quiet_cycles;
    bit          grow;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct[idle_mode]);
    end

    always @(posedge i_clk) begin
        t_req q;
        t_rsp a;
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                a.read_value = rsp_ch.read_value;
                a.status     = rsp_ch.status;
                a.length     = rsp_ch.length;
                sb.check_response(a);
            end
            if (req_ch.valid && req_ch.ready) begin
                q.func     = req_ch.func;
                q.position = req_ch.position;
                q.value    = req_ch.value;
                sb.note_request(q);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("positional_list_insert_delete_unit: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_request(input t_req r);
        while ($urandom_range(0, 99) < send_idle_pct[idle_mode]) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.func     <= r.func;
        req_ch.position <= r.position;
        req_ch.value    <= r.value;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic issue(input logic [FUNC_W-1:0] fn, input int pos,
                         input logic signed [DATA_W-1:0] val);
        t_req r;
        r.func     = fn;
        r.position = CNT_W'(pos);
        r.value    = val;
        send_request(r);
    endtask

    function automatic t_req random_request();
        t_req r;
        int   k;
        int   cnt;
        cnt = sb.fill;
        if (cnt == LIST_CAP)
            grow = 1'b0;
        else if (cnt == 0)
            grow = 1'b1;
        else if ($urandom_range(0, 99) < 3)
            grow = !grow;
        k = $urandom_range(0, 99);
        if (k < 4) begin
            r.func = FUNC_W'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
        end else if (k < 28) begin
            r.func = FN_READ;
        end else if (k < (grow ? 82 : 46)) begin
            case ($urandom_range(0, 2))
                0:       r.func = FN_INS_HEAD;
                1:       r.func = FN_INS_TAIL;
                default: r.func = FN_INS_POS;
            endcase
        end else begin
            r.func = FN_DELETE;
        end
        if ($urandom_range(0, 99) < 85)
            r.position = CNT_W'($urandom_range(0, cnt));
        else
            r.position = CNT_W'($urandom_range(0, (1 << CNT_W) - 1));
        case ($urandom_range(0, 9))
            0:       r.value = VAL_MIN;
            1:       r.value = VAL_MAX;
            2:       r.value = '0;
            3:       r.value = -1;
            default: r.value = $urandom;
        endcase
        return r;
    endfunction

    initial begin
        t_req r;
        int   counted;
        int   i;
        i_rst_n         = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.func     = '0;
        req_ch.position = '0;
        req_ch.value    = '0;
        rsp_ch.ready    = 1'b0;
        idle_mode       = 0;
        quiet_cycles    = 0;
        grow            = 1'b1;
        counted         = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty list edges
        issue(FN_READ, 0, '0);
        issue(FN_DELETE, 0, '0);
        issue(FN_INS_POS, 1, 32'sh1234_5678);
        issue(FN_INS_POS, 0, VAL_MAX);
        issue(FN_INS_HEAD, 0, VAL_MIN);
        issue(FN_INS_TAIL, 0, '0);
        issue(FN_INS_TAIL, 0, -1);
        issue(FN_INS_POS, 2, 32'sh5555_5555);
        issue(FN_INS_POS, 5, 32'shAAAA_AAAA);
        for (i = 0; i < 10; i++)
            issue(FN_INS_POS, i, 32'sh0F0F_0000 + i);
        // full list: out of range wins over full
        issue(FN_INS_TAIL, 0, 32'sh0BAD_0BAD);
        issue(FN_INS_POS, 17, 32'sh0BAD_0BAD);
        issue(FN_READ, 15, '0);
        issue(FN_READ, 16, '0);
        issue(FN_DELETE, 15, '0);
        issue(FN_DELETE, 0, '0);
        issue(FN_SPARE_HI, 31, -1);

        while (counted < RANDOM_ITEMS) begin
            idle_mode = (counted * 4) / RANDOM_ITEMS;
            r = random_request();
            if (r.func <= FN_DELETE)
                counted++;
            send_request(r);
        end
        req_ch.valid <= 1'b0;

        while (sb.owed.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("positional_list_insert_delete_unit: match");
        else
            $display("positional_list_insert_delete_unit: mismatch");
        $finish;
    end

endmodule
